// ===== sv/timestamp_descending_exchange_sort_defines.svh =====
// Assertion macros for the timestamp exchange sort.
`ifndef TIMESTAMP_DESCENDING_EXCHANGE_SORT_DEFINES_SVH
`define TIMESTAMP_DESCENDING_EXCHANGE_SORT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDES_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tdes_pkg.sv =====
// Types, constants and microcode table for the timestamp exchange sort.
`default_nettype none
package tdes_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int TAG_W           = 16;
	localparam int KEY_W           = 34;

	typedef struct packed {
		logic [15:0] record_tag;
		logic [6:0]  year_offset;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [6:0]  half_second;
		logic        last_entry;
	} rec_t;

	typedef struct packed {
		logic [15:0] sorted_tag;
		logic        last_out;
		logic        overflow;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Microprogram steps.
	typedef enum logic [2:0] {
		UPC_WAIT,
		UPC_RD_I,
		UPC_RD_J,
		UPC_SCAN,
		UPC_EMIT
	} upc_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_J,
		RD_J1
	} rd_sel_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_LOAD_LAST,
		C_J_END,
		C_J1_END,
		C_FIN
	} cond_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		logic    wait_in;
		logic    set_j;
		logic    load_cur;
		logic    exch;
		logic    emit;
		cond_t   cond;
		upc_t    tgt_hit;
		upc_t    tgt_miss;
	} ctl_t;

	typedef struct packed {
		logic load_last;
		logic j_end;
		logic j1_end;
		logic fin;
	} stat_t;

	function automatic ctl_t ucode_rom(upc_t pc);
		ctl_t w;
		w = '{rd_sel: RD_I, wait_in: 1'b0, set_j: 1'b0, load_cur: 1'b0, exch: 1'b0,
			emit: 1'b0, cond: C_ALWAYS, tgt_hit: UPC_WAIT, tgt_miss: UPC_WAIT};
		unique case (pc)
			UPC_WAIT: begin
				w.wait_in  = 1'b1;
				w.cond     = C_LOAD_LAST;
				w.tgt_hit  = UPC_RD_I;
				w.tgt_miss = UPC_WAIT;
			end
			UPC_RD_I: begin
				w.rd_sel   = RD_I;
				w.set_j    = 1'b1;
				w.tgt_hit  = UPC_RD_J;
				w.tgt_miss = UPC_RD_J;
			end
			UPC_RD_J: begin
				w.rd_sel   = RD_J;
				w.load_cur = 1'b1;
				w.cond     = C_J_END;
				w.tgt_hit  = UPC_EMIT;
				w.tgt_miss = UPC_SCAN;
			end
			UPC_SCAN: begin
				w.rd_sel   = RD_J1;
				w.exch     = 1'b1;
				w.cond     = C_J1_END;
				w.tgt_hit  = UPC_EMIT;
				w.tgt_miss = UPC_SCAN;
			end
			UPC_EMIT: begin
				w.emit     = 1'b1;
				w.cond     = C_FIN;
				w.tgt_hit  = UPC_WAIT;
				w.tgt_miss = UPC_RD_I;
			end
			default: begin
				w.tgt_hit  = UPC_WAIT;
				w.tgt_miss = UPC_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/tdes_mem.sv =====
// Entry memory: one write port, one registered read port.
`default_nettype none
module tdes_mem
	import tdes_pkg::*;
#(
	parameter int DEPTH = MAX_ENTRIES_DEF,
	parameter int AW    = $clog2(MAX_ENTRIES_DEF)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/tdes_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module tdes_seq
	import tdes_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctl_t       ctl
);

	upc_t pc_q;
	upc_t pc_d;
	logic hit;

	always_comb begin
		ctl = ucode_rom(pc_q);
	end

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:    hit = 1'b1;
			C_LOAD_LAST: hit = stat.load_last;
			C_J_END:     hit = stat.j_end;
			C_J1_END:    hit = stat.j1_end;
			C_FIN:       hit = stat.fin;
			default:     hit = 1'b1;
		endcase
		pc_d = hit ? ctl.tgt_hit : ctl.tgt_miss;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/timestamp_descending_exchange_sort.sv =====
// Top level: record loading, exchange-sort datapath and result output.
`default_nettype none
`include "timestamp_descending_exchange_sort_defines.svh"

// Loads records one per cycle while busy is low (an item is taken when start is
// high and busy is low). The record with last_entry set closes the set; busy then
// rises and the block sorts newest first and streams the tags out, one per
// res_valid pulse, the last flagged by last_out. The single read port of the
// entry memory is visited once per compare.
// Results cannot be held off: res_valid flags each for exactly one cycle.
// Records beyond MAX_ENTRIES are dropped and overflow is set on that set's results.
module timestamp_descending_exchange_sort
	import tdes_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire rec_t rec,
	output logic      busy,
	output logic      res_valid,
	output res_t      res
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	ctl_t   ctl;
	stat_t  stat;
	entry_t rd_data;
	entry_t cur_q;
	entry_t new_entry;
	entry_t wdata;

	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] j_inc;
	logic [IW-1:0] i_q;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic          ovf_q;
	logic          accept;
	logic          full;
	logic          swap;
	logic          we;
	logic          res_valid_q;
	res_t          res_q;

	tdes_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign busy   = !ctl.wait_in;
	assign accept = start && ctl.wait_in;
	assign full   = (count_q == CW'(MAX_ENTRIES));
	assign j_inc  = j_q + CW'(1);
	assign swap   = (cur_q.key < rd_data.key);

	assign new_entry.key = {rec.year_offset, rec.month, rec.day, rec.hour, rec.minute,
		rec.half_second};
	assign new_entry.tag = rec.record_tag;

	assign stat.load_last = accept && rec.last_entry;
	assign stat.j_end     = (j_q == count_q);
	assign stat.j1_end    = (j_inc == count_q);
	assign stat.fin       = ((CW'(i_q) + CW'(1)) == count_q);

	always_comb begin
		unique case (ctl.rd_sel)
			RD_I:    raddr = i_q;
			RD_J:    raddr = j_q[IW-1:0];
			RD_J1:   raddr = j_inc[IW-1:0];
			default: raddr = i_q;
		endcase
	end

	// Swap writes the held entry back into slot j; loads fill the next free slot.
	always_comb begin
		we    = (accept && !full) || (ctl.exch && swap);
		waddr = ctl.exch ? j_q[IW-1:0] : count_q[IW-1:0];
		wdata = ctl.exch ? cur_q : new_entry;
	end

	tdes_mem #(
		.DEPTH (MAX_ENTRIES),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= ctl.emit;
			if (accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (ctl.set_j) begin
				j_q <= CW'(i_q) + CW'(1);
			end
			if (ctl.exch) begin
				j_q <= j_inc;
			end
			if (ctl.emit) begin
				if (stat.fin) begin
					// drop the finished set
					i_q     <= '0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
		end
	end

	// Hold slot i's running value; it is final once its scan ends.
	always_ff @(posedge clk) begin
		if (ctl.load_cur || (ctl.exch && swap)) begin
			cur_q <= rd_data;
		end
		if (ctl.emit) begin
			res_q.sorted_tag <= cur_q.tag;
			res_q.last_out   <= stat.fin;
			res_q.overflow   <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`TDES_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES), "entry count beyond capacity")
	`TDES_ASSERT_NOW(a_exch_in_set, ctl.exch, j_q < count_q, "exchange outside the loaded set")
	`TDES_ASSERT_NOW(a_ovf_full, ovf_q, full, "overflow flagged with free slots")
	`TDES_ASSERT_NOW(a_last_free, res_valid && res.last_out, !busy && (count_q == '0), "set held")

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the timestamp exchange sort: queued records, running sort predictor.
`timescale 1ns / 100ps

module tb_top;
	import tdes_pkg::*;

	localparam int CAPACITY     = MAX_ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 120;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 250;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	rec_t rec    = '0;
	logic busy;
	logic res_valid;
	res_t res;

	rec_t   record_q[$];
	res_t   newest_first_q[$];
	entry_t held_entries[CAPACITY];
	int     held_count   = 0;
	logic   dropped_seen = 1'b0;
	logic   taken        = 1'b0;
	int     sent_count   = 0;
	int     total_items  = 0;
	int     idle_pct     = 0;
	int     error_count  = 0;
	int     cycle_count  = 0;

	timestamp_descending_exchange_sort #(.MAX_ENTRIES(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.rec(rec),
		.busy(busy),
		.res_valid(res_valid),
		.res(res)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	function automatic rec_t make_rec(input logic [15:0] tag, input logic [6:0] yr,
		input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hr,
		input logic [5:0] mi, input logic [6:0] hs, input logic fin);
		return {tag, yr, mo, dy, hr, mi, hs, fin};
	endfunction

	function automatic rec_t random_rec(input logic fin);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6)
			return make_rec(16'($urandom), 7'($urandom_range(0, 127)), 4'($urandom_range(1, 12)),
				5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
				6'($urandom_range(0, 59)), 7'($urandom_range(0, 119)), fin);
		// narrow pool of timestamps so equal keys show up often
		if (mode < 8)
			return make_rec(16'($urandom), 7'($urandom_range(0, 1)), 4'd1, 5'd1,
				5'($urandom_range(0, 1)), 6'd0, 7'($urandom_range(0, 1)), fin);
		// raw field values, out-of-range ones included
		return make_rec(16'($urandom), 7'($urandom), 4'($urandom), 5'($urandom),
			5'($urandom), 6'($urandom), 7'($urandom), fin);
	endfunction

	// Store the record, and on the closing one run the exchange pass and queue the tags.
	task automatic absorb_record(input rec_t r);
		entry_t swap;
		if (held_count < CAPACITY) begin
			held_entries[held_count].key = {r.year_offset, r.month, r.day, r.hour, r.minute,
				r.half_second};
			held_entries[held_count].tag = r.record_tag;
			held_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (r.last_entry) begin
			for (int i = 0; i < held_count; i++)
				for (int j = i + 1; j < held_count; j++)
					if (held_entries[i].key < held_entries[j].key) begin
						swap            = held_entries[i];
						held_entries[i] = held_entries[j];
						held_entries[j] = swap;
					end
			for (int k = 0; k < held_count; k++)
				newest_first_q.push_back('{sorted_tag: held_entries[k].tag,
					last_out: (k == held_count - 1), overflow: dropped_seen});
			held_count   = 0;
			dropped_seen = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			idle_pct = (sent_count < total_items / 3) ? 33 :
				(sent_count < 2 * total_items / 3) ? 86 : 0;
			if (record_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				rec   <= record_q.pop_front();
				start <= 1'b1;
				sent_count++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			taken <= start && !busy;
			if (res_valid !== 1'b0) begin
				if (newest_first_q.size() == 0) begin
					report_mismatch($sformatf("tag %h arrived with nothing pending",
						res.sorted_tag));
				end else begin
					want = newest_first_q.pop_front();
					if (res.sorted_tag !== want.sorted_tag)
						report_mismatch($sformatf("sorted_tag %h, expected %h",
							res.sorted_tag, want.sorted_tag));
					if (res.last_out !== want.last_out)
						report_mismatch($sformatf("last_out %b, expected %b",
							res.last_out, want.last_out));
					if (res.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %b, expected %b",
							res.overflow, want.overflow));
				end
			end
			if (start && !busy)
				absorb_record(rec);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int set_size;
		int directed;
		// lone record, all-zero fields
		record_q.push_back(make_rec(16'h0000, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 7'd0, 1'b1));
		// all-ones fields, earliest and latest valid stamps, equal keys
		record_q.push_back(make_rec(16'hFFFF, 7'h7F, 4'hF, 5'h1F, 5'h1F, 6'h3F, 7'h7F, 1'b0));
		record_q.push_back(make_rec(16'h0001, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 7'd0, 1'b0));
		record_q.push_back(make_rec(16'h0002, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 7'd0, 1'b0));
		record_q.push_back(make_rec(16'hA5A5, 7'd127, 4'd12, 5'd31, 5'd23, 6'd59, 7'd119, 1'b0));
		record_q.push_back(make_rec(16'h5A5A, 7'd127, 4'd12, 5'd31, 5'd23, 6'd59, 7'd119, 1'b0));
		record_q.push_back(make_rec(16'h1234, 7'd64, 4'd6, 5'd15, 5'd12, 6'd30, 7'd60, 1'b1));
		// overrun the store; the closing record itself is dropped
		for (int n = 0; n < CAPACITY + 2; n++)
			record_q.push_back(make_rec(16'h8000 | 16'(n), 7'(n), 4'd3, 5'd9, 5'd4, 6'd7,
				7'(n % 3), (n == CAPACITY + 1)));
		directed = record_q.size();
		while (record_q.size() < directed + RANDOM_ITEMS) begin
			set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
				: $urandom_range(1, CAPACITY);
			for (int n = 0; n < set_size; n++)
				record_q.push_back(random_rec(n == set_size - 1));
		end
		total_items = record_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (record_q.size() != 0 || start || newest_first_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/tdes_pkg.sv
sv/tdes_mem.sv
sv/tdes_seq.sv
sv/timestamp_descending_exchange_sort.sv
test/tb_top.sv
